// ===== design/kprc_pkg.sv =====
package kprc_pkg;

    // Held-time counter width and the width of the poll interval
    localparam int TIME_BITS    = 40;
    localparam int ELAPSED_BITS = 32;
    // Timing registers are fixed at 40 bits
    localparam int CFG_BITS     = 40;
    localparam int CFG_IDX_BITS = 2;
    // Common width for time-against-threshold compares
    localparam int CMP_BITS     = 64;

    // Timing register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONGPRESS_DELAY = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_SETTLE  = 2'd2;

    // Timing register reset values
    localparam logic [CFG_BITS-1:0] RST_REPEAT_INTERVAL = 40'd100000000;
    localparam logic [CFG_BITS-1:0] RST_LONGPRESS_DELAY = 40'd500000000;
    localparam logic [CFG_BITS-1:0] RST_RELEASE_SETTLE  = 40'd10000000;

    typedef enum logic [2:0] {
        KEY_UP     = 3'd0,
        KEY_DOWN   = 3'd1,
        KEY_ENTER  = 3'd2,
        KEY_RIGHT  = 3'd3,
        KEY_LEFT   = 3'd4,
        KEY_ESCAPE = 3'd5
    } t_key_event;

    typedef struct packed {
        logic [CFG_BITS-1:0] repeat_interval;
        logic [CFG_BITS-1:0] longpress_delay;
        logic [CFG_BITS-1:0] release_settle;
    } t_cfg;

    // Event request from one key: fire, and whether it is the power combo
    typedef struct packed {
        logic fire;
        logic combo;
    } t_key_fire;

    // Events of one poll, in order, with their count
    typedef struct packed {
        logic [1:0] cnt;
        t_key_event ev0;
        t_key_event ev1;
        t_key_event ev2;
    } t_evt_grp;

endpackage

// ===== design/kprc_cfg.sv =====
module kprc_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kprc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [kprc_pkg::CFG_BITS-1:0]        i_cfg_data,
    output kprc_pkg::t_cfg                       o_cfg
);

    kprc_pkg::t_cfg r_cfg;
    kprc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the register index; drop writes beyond the list
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                kprc_pkg::CFG_REPEAT_INTERVAL: n_cfg.repeat_interval = i_cfg_data;
                kprc_pkg::CFG_LONGPRESS_DELAY: n_cfg.longpress_delay = i_cfg_data;
                kprc_pkg::CFG_RELEASE_SETTLE:  n_cfg.release_settle  = i_cfg_data;
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_interval <= kprc_pkg::RST_REPEAT_INTERVAL;
            r_cfg.longpress_delay <= kprc_pkg::RST_LONGPRESS_DELAY;
            r_cfg.release_settle  <= kprc_pkg::RST_RELEASE_SETTLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/kprc_key.sv =====
module kprc_key (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  logic                                 i_pressed,
    input  logic [kprc_pkg::ELAPSED_BITS-1:0]    i_delta,
    input  logic                                 i_is_power,
    input  logic                                 i_power_seen,
    input  kprc_pkg::t_cfg                       i_cfg,
    output kprc_pkg::t_key_fire                  o_fire,
    output logic                                 o_level
);

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_PRESSED   = 2'd1,
        PH_RELREPORT = 2'd2
    } t_phase;

    t_phase                              r_phase;
    t_phase                              n_phase;
    logic [kprc_pkg::TIME_BITS-1:0]      r_time;
    logic [kprc_pkg::TIME_BITS-1:0]      n_time;
    logic                                r_rep;
    logic                                n_rep;
    logic                                r_long;
    logic                                n_long;
    logic                                r_level;

    logic [kprc_pkg::TIME_BITS:0]        sum;
    logic [kprc_pkg::TIME_BITS-1:0]      held;
    logic [kprc_pkg::CMP_BITS-1:0]       held_x;
    logic                                past_repeat;
    logic                                past_long;
    logic                                past_settle;

    // Saturating held time
    assign sum  = {1'b0, r_time} + (kprc_pkg::TIME_BITS + 1)'(i_delta);
    assign held = sum[kprc_pkg::TIME_BITS] ? '1 : sum[kprc_pkg::TIME_BITS-1:0];

    assign held_x      = kprc_pkg::CMP_BITS'(held);
    assign past_repeat = held_x >= kprc_pkg::CMP_BITS'(i_cfg.repeat_interval);
    assign past_long   = held_x >= kprc_pkg::CMP_BITS'(i_cfg.longpress_delay);
    assign past_settle = held_x >= kprc_pkg::CMP_BITS'(i_cfg.release_settle);

    assign o_level = r_level;

    // Next phase, time and flags, and the event this poll raises
    always_comb begin
        n_phase      = r_phase;
        n_time       = held;
        n_rep        = r_rep;
        n_long       = r_long;
        o_fire.fire  = 1'b0;
        o_fire.combo = 1'b0;
        case (r_phase)
            PH_RELEASED: begin
                if (i_pressed) begin
                    n_time  = '0;
                    n_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (i_pressed) begin
                    if (r_rep && past_repeat) begin
                        o_fire.fire = 1'b1;
                        n_time      = '0;
                    end else if (!r_long && past_long) begin
                        if (i_is_power) begin
                            o_fire.fire  = 1'b1;
                            o_fire.combo = 1'b1;
                        end else if (!i_power_seen) begin
                            o_fire.fire = 1'b1;
                            n_time      = '0;
                            n_rep       = 1'b1;
                        end
                        n_long = 1'b1;
                    end
                end else if (!r_long) begin
                    // Short press: report on release
                    o_fire.fire = 1'b1;
                    n_phase     = PH_RELREPORT;
                end else if (past_settle) begin
                    n_time  = '0;
                    n_rep   = 1'b0;
                    n_long  = 1'b0;
                    n_phase = PH_RELEASED;
                end
            end
            default: begin
                // Release-report, and the unused code: back to released
                n_time  = '0;
                n_rep   = 1'b0;
                n_long  = 1'b0;
                n_phase = PH_RELEASED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_time  <= '0;
            r_rep   <= 1'b0;
            r_long  <= 1'b0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_time  <= n_time;
            r_rep   <= n_rep;
            r_long  <= n_long;
            r_level <= i_pressed;
        end
    end

endmodule

// ===== design/kprc_out.sv =====
module kprc_out (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  kprc_pkg::t_evt_grp       i_grp,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  logic                     i_stall,
    output kprc_pkg::t_key_event     o_key_event,
    output logic                     o_last_event
);

    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    kprc_pkg::t_key_event    r_ev0;
    kprc_pkg::t_key_event    r_ev1;
    kprc_pkg::t_key_event    r_ev2;
    kprc_pkg::t_key_event    n_ev0;
    kprc_pkg::t_key_event    n_ev1;
    kprc_pkg::t_key_event    n_ev2;
    logic                    take;

    assign o_valid      = r_cnt != 2'd0;
    assign o_key_event  = r_ev0;
    assign o_last_event = r_cnt == 2'd1;
    assign take         = o_valid && !i_stall;
    assign o_can_load   = (r_cnt == 2'd0) || (o_last_event && take);

    // Load a new poll's events, or advance to the next one on a transaction
    always_comb begin
        n_cnt = r_cnt;
        n_ev0 = r_ev0;
        n_ev1 = r_ev1;
        n_ev2 = r_ev2;
        if (i_load) begin
            n_cnt = i_grp.cnt;
            n_ev0 = i_grp.ev0;
            n_ev1 = i_grp.ev1;
            n_ev2 = i_grp.ev2;
        end else if (take) begin
            n_cnt = r_cnt - 2'd1;
            n_ev0 = r_ev1;
            n_ev1 = r_ev2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev0 <= n_ev0;
        r_ev1 <= n_ev1;
        r_ev2 <= n_ev2;
    end

endmodule

// ===== design/keypad_longpress_repeat_combo.sv =====
// Channel   Direction  Handshake                  Payload
// poll      in         i_valid / o_stall          i_vol_up_pressed, i_vol_down_pressed,
//                                                 i_power_pressed, i_elapsed_ns
// event     out        o_valid / i_stall          o_key_event, o_last_event
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A poll is registered, then all three keys update and their events load the event register
// in the same cycle; the register then presents a poll's events one per cycle when not
// stalled, at most three per poll.
// A poll that raises no event shows nothing on the output.
// Reset (synchronous, active low) releases all keys and restores the timing registers.
// A stalled output holds its event; the poll register then fills and stalls input.
module keypad_longpress_repeat_combo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_vol_up_pressed,
    input  logic                                 i_vol_down_pressed,
    input  logic                                 i_power_pressed,
    input  logic [kprc_pkg::ELAPSED_BITS-1:0]    i_elapsed_ns,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [2:0]                           o_key_event,
    output logic                                 o_last_event,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kprc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [kprc_pkg::CFG_BITS-1:0]        i_cfg_data
);

    logic                                r_in_valid;
    logic                                r_in_up;
    logic                                r_in_down;
    logic                                r_in_pwr;
    logic [kprc_pkg::ELAPSED_BITS-1:0]   r_in_delta;

    kprc_pkg::t_cfg                      cfg;
    kprc_pkg::t_key_fire                 fire_up;
    kprc_pkg::t_key_fire                 fire_down;
    kprc_pkg::t_key_fire                 fire_pwr;
    logic                                level_up;
    logic                                level_down;
    logic                                level_pwr;
    kprc_pkg::t_key_event                code_pwr;
    kprc_pkg::t_evt_grp                  grp;
    kprc_pkg::t_key_event                out_ev;
    logic                                can_load;
    logic                                step;
    logic                                in_take;

    assign step    = r_in_valid && can_load;
    assign o_stall = r_in_valid && !can_load;
    assign in_take = i_valid && !o_stall;

    // Hold the poll until its events can load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_up    <= i_vol_up_pressed;
            r_in_down  <= i_vol_down_pressed;
            r_in_pwr   <= i_power_pressed;
            r_in_delta <= i_elapsed_ns;
        end
    end

    kprc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Volume keys see the power level of the previous poll
    kprc_key u_key_up (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pressed    (r_in_up),
        .i_delta      (r_in_delta),
        .i_is_power   (1'b0),
        .i_power_seen (level_pwr),
        .i_cfg        (cfg),
        .o_fire       (fire_up),
        .o_level      (level_up)
    );

    kprc_key u_key_down (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pressed    (r_in_down),
        .i_delta      (r_in_delta),
        .i_is_power   (1'b0),
        .i_power_seen (level_pwr),
        .i_cfg        (cfg),
        .o_fire       (fire_down),
        .o_level      (level_down)
    );

    kprc_key u_key_pwr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pressed    (r_in_pwr),
        .i_delta      (r_in_delta),
        .i_is_power   (1'b1),
        .i_power_seen (1'b0),
        .i_cfg        (cfg),
        .o_fire       (fire_pwr),
        .o_level      (level_pwr)
    );

    // Power combo: down wins over up; both use this poll's levels
    always_comb begin
        if (!fire_pwr.combo) begin
            code_pwr = kprc_pkg::KEY_ENTER;
        end else if (r_in_down) begin
            code_pwr = kprc_pkg::KEY_RIGHT;
        end else if (r_in_up) begin
            code_pwr = kprc_pkg::KEY_LEFT;
        end else begin
            code_pwr = kprc_pkg::KEY_ESCAPE;
        end
    end

    // Pack the fired events in key order
    always_comb begin
        grp.cnt = 2'(fire_up.fire) + 2'(fire_down.fire) + 2'(fire_pwr.fire);
        if (fire_up.fire) begin
            grp.ev0 = kprc_pkg::KEY_UP;
        end else if (fire_down.fire) begin
            grp.ev0 = kprc_pkg::KEY_DOWN;
        end else begin
            grp.ev0 = code_pwr;
        end
        if (fire_up.fire && fire_down.fire) begin
            grp.ev1 = kprc_pkg::KEY_DOWN;
        end else begin
            grp.ev1 = code_pwr;
        end
        grp.ev2 = code_pwr;
    end

    kprc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step),
        .i_grp        (grp),
        .o_can_load   (can_load),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_key_event  (out_ev),
        .o_last_event (o_last_event)
    );

    assign o_key_event = out_ev;

endmodule

// ===== design/kprc_checker.sv =====
module kprc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_stall,
    input  logic          o_valid,
    input  logic          i_stall,
    input  logic [2:0]    o_key_event,
    input  logic          o_last_event
);

    // Reset empties the event register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("event valid after reset");

    // Reset leaves the poll register free
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("poll stall after reset");

    // A stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_event) && $stable(o_last_event))
        else $error("stalled event changed");

    // Events of one poll leave back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_event && !i_stall |=> o_valid)
        else $error("gap inside a poll's events");

    // Only defined event codes leave
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_key_event <= 3'd5)
        else $error("undefined event code");

endmodule

bind keypad_longpress_repeat_combo kprc_checker u_kprc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_key_event  (o_key_event),
    .o_last_event (o_last_event)
);
